@@ sv/psplit_pkg.sv @@
package psplit_pkg;

  localparam int CoordWidthDefault = 16;
  localparam int FracBits = 4;
  localparam int FieldWidth = 16;
  localparam int CfgIndexWidth = 2;

  localparam logic [CfgIndexWidth-1:0] RegCutStartX = 2'd0;
  localparam logic [CfgIndexWidth-1:0] RegCutStartY = 2'd1;
  localparam logic [CfgIndexWidth-1:0] RegCutEndX = 2'd2;
  localparam logic [CfgIndexWidth-1:0] RegCutEndY = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EDGE,
    ST_MUL,
    ST_NORM,
    ST_TEST,
    ST_MULQ,
    ST_STARTQ,
    ST_DIVQ,
    ST_EMIT1,
    ST_EMIT2,
    ST_NEXT
  } state_t;

endpackage

@@ sv/psplit_if.sv @@
interface psplit_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] vertex_x;
  logic signed [15:0] vertex_y;
  logic final_vertex;
  modport source (output valid, vertex_x, vertex_y, final_vertex, input ready);
  modport sink (input valid, vertex_x, vertex_y, final_vertex, output ready);
endinterface

interface psplit_out_if;
  logic valid;
  logic ready;
  logic side;
  logic signed [15:0] seg_start_x;
  logic signed [15:0] seg_start_y;
  logic signed [15:0] seg_end_x;
  logic signed [15:0] seg_end_y;
  logic run_last;
  modport source (output valid, side, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
                  run_last, input ready);
  modport sink (input valid, side, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
                run_last, output ready);
endinterface

@@ sv/psplit_div.sv @@
module psplit_div #(
  parameter int NW = 52,
  parameter int DW = 36,
  parameter int QW = 17
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic done,
  output logic [QW-1:0] quo
);
  localparam int CntW = $clog2(QW + 1);
  logic [QW-1:0] q;
  logic [NW-1:0] rem;
  logic [NW-1:0] dsh;
  logic [NW-1:0] diff;
  logic [CntW-1:0] cnt;
  logic busy;

  assign diff = rem - dsh;
  assign quo = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
      q <= '0;
      rem <= '0;
      dsh <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CntW'(QW);
        q <= '0;
        rem <= num;
        dsh <= NW'(den) << (QW - 1);
      end else if (busy) begin
        if (rem >= dsh) begin
          rem <= diff;
          q <= {q[QW-2:0], 1'b1};
        end else begin
          q <= {q[QW-2:0], 1'b0};
        end
        dsh <= dsh >> 1;
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

@@ sv/polygon_split_by_segment_unit.sv @@
// Splits polygon edges along a cut segment held in four configuration registers.
// Vertices enter on the in channel one word at a time; final_vertex closes the
// polygon back to its first vertex. Each edge of nonzero length yields one word
// on the out channel, or two words when it crosses the cut, the side flag
// toggling between them. run_last marks the last word caused by one vertex.
// The block takes one vertex at a time and is not ready while it works. An edge
// that passes whole is tested on the shared multiplier; a crossing edge then
// makes two passes of multiply, divider start and a wait on the shared divider,
// which yields one quotient bit per cycle over 17 bits. The slowest vertex is a
// final one with two crossing edges. When the receiver stalls, the result word
// holds in the output register and the block waits. Synchronous reset clears
// the cut registers, the stored vertices and the side flag, and leaves the block
// idle and ready.
module polygon_split_by_segment_unit import psplit_pkg::*; #(
  parameter int COORD_WIDTH = CoordWidthDefault
) (
  input  logic clk,
  input  logic rst,
  psplit_in_if.sink in_ch,
  psplit_out_if.source out_ch,
  input  logic cfg_we,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [FieldWidth-1:0] cfg_data
);
  localparam int EW = (COORD_WIDTH < FieldWidth) ? COORD_WIDTH : FieldWidth;
  localparam int CW = FieldWidth + 1;
  localparam int AW = 36;
  localparam int PW = CW + AW;
  localparam int NW = 52;

  state_t state, state_next;
  logic signed [FieldWidth-1:0] csx, csy, cex, cey;
  logic signed [FieldWidth-1:0] fx, fy, px, py, vx, vy;
  logic have_prev, cur_side, last, second, doing_y, neg;
  logic [2:0] mstep;
  logic signed [FieldWidth-1:0] ex0, ey0, ex1, ey1, ix, iy;
  logic signed [CW-1:0] ax, ay, bx, by, cx, cy;
  logic signed [AW-1:0] den, na, nb, prod;
  logic signed [CW-1:0] mul_a;
  logic signed [AW-1:0] mul_b;
  logic signed [PW-1:0] mul_full;
  logic [PW-1:0] pmag;
  logic [NW-2:0] pm;
  logic div_start, div_done;
  logic [NW-1:0] dnum;
  logic [AW-1:0] dden;
  logic [CW-1:0] dquo;
  logic signed [CW:0] qs;
  logic signed [FieldWidth-1:0] coord_new;
  logic zero_len, edge2_live, piece_last, crosses;

  function automatic logic signed [FieldWidth-1:0] sx(input logic [FieldWidth-1:0] v);
    logic [FieldWidth-1:0] m;
    m = v << (FieldWidth - EW);
    return $signed(m) >>> (FieldWidth - EW);
  endfunction

  assign in_ch.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      csx <= '0; csy <= '0; cex <= '0; cey <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegCutStartX: csx <= sx(cfg_data);
        RegCutStartY: csy <= sx(cfg_data);
        RegCutEndX: cex <= sx(cfg_data);
        RegCutEndY: cey <= sx(cfg_data);
        default: ;
      endcase
    end
  end

  assign ex0 = second ? vx : px;
  assign ey0 = second ? vy : py;
  assign ex1 = second ? fx : vx;
  assign ey1 = second ? fy : vy;

  assign zero_len = (ex0 == ex1) && (ey0 == ey1);
  assign edge2_live = last && ((vx != fx) || (vy != fy));
  assign piece_last = second || !edge2_live;
  assign crosses = (den != '0) && !na[AW-1] && (na <= den) && !nb[AW-1] && (nb <= den);

  always_comb begin
    mul_a = ay;
    mul_b = AW'(bx);
    if (state == ST_MULQ) begin
      mul_a = doing_y ? ay : ax;
      mul_b = na;
    end else begin
      case (mstep)
        3'd0: begin mul_a = ay; mul_b = AW'(bx); end
        3'd1: begin mul_a = ax; mul_b = AW'(by); end
        3'd2: begin mul_a = by; mul_b = AW'(cx); end
        3'd3: begin mul_a = bx; mul_b = AW'(cy); end
        3'd4: begin mul_a = ax; mul_b = AW'(cy); end
        default: begin mul_a = ay; mul_b = AW'(cx); end
      endcase
    end
  end

  assign mul_full = mul_a * mul_b;
  assign prod = mul_full[AW-1:0];
  assign pmag = mul_full[PW-1] ? $unsigned(-mul_full) : $unsigned(mul_full);

  // The divider returns (2|n| + d) / 2d, which rounds |n| / d to nearest.
  assign dnum = {pm, 1'b0} + NW'($unsigned(den));
  assign dden = {den[AW-2:0], 1'b0};
  assign qs = neg ? -$signed({1'b0, dquo}) : $signed({1'b0, dquo});
  assign coord_new = FieldWidth'((doing_y ? ey0 : ex0) + qs);

  psplit_div #(.NW(NW), .DW(AW), .QW(CW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(dnum), .den(dden),
    .done(div_done), .quo(dquo)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    div_start = 1'b0;
    unique case (state)
      ST_IDLE: if (in_ch.valid) state_next = have_prev ? ST_EDGE : ST_NEXT;
      ST_EDGE: state_next = zero_len ? ST_NEXT : ST_MUL;
      ST_MUL: if (mstep == 3'd5) state_next = ST_NORM;
      ST_NORM: state_next = ST_TEST;
      ST_TEST: state_next = crosses ? ST_MULQ : ST_EMIT2;
      ST_MULQ: state_next = ST_STARTQ;
      ST_STARTQ: begin
        div_start = 1'b1;
        state_next = ST_DIVQ;
      end
      ST_DIVQ: if (div_done) state_next = doing_y ? ST_EMIT1 : ST_MULQ;
      ST_EMIT1: if (out_ch.ready) state_next = ST_EMIT2;
      ST_EMIT2: if (out_ch.ready) state_next = ST_NEXT;
      ST_NEXT: state_next = (have_prev && last && !second) ? ST_EDGE : ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
      cur_side <= 1'b0;
      last <= 1'b0;
      second <= 1'b0;
      doing_y <= 1'b0;
      neg <= 1'b0;
      mstep <= '0;
      fx <= '0; fy <= '0; px <= '0; py <= '0; vx <= '0; vy <= '0;
      ix <= '0; iy <= '0;
      ax <= '0; ay <= '0; bx <= '0; by <= '0; cx <= '0; cy <= '0;
      den <= '0; na <= '0; nb <= '0;
      pm <= '0;
      out_ch.valid <= 1'b0;
      out_ch.side <= 1'b0;
      out_ch.seg_start_x <= '0; out_ch.seg_start_y <= '0;
      out_ch.seg_end_x <= '0; out_ch.seg_end_y <= '0;
      out_ch.run_last <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: if (in_ch.valid) begin
          vx <= sx(in_ch.vertex_x);
          vy <= sx(in_ch.vertex_y);
          last <= in_ch.final_vertex;
          second <= 1'b0;
        end
        ST_EDGE: begin
          ax <= CW'(ex1) - CW'(ex0);
          ay <= CW'(ey1) - CW'(ey0);
          bx <= CW'(csx) - CW'(cex);
          by <= CW'(csy) - CW'(cey);
          cx <= CW'(ex0) - CW'(csx);
          cy <= CW'(ey0) - CW'(csy);
          mstep <= '0;
        end
        ST_MUL: begin
          case (mstep)
            3'd0: den <= prod;
            3'd1: den <= den - prod;
            3'd2: na <= prod;
            3'd3: na <= na - prod;
            3'd4: nb <= prod;
            default: nb <= nb - prod;
          endcase
          mstep <= mstep + 3'd1;
        end
        ST_NORM: if (den[AW-1]) begin
          den <= -den;
          na <= -na;
          nb <= -nb;
        end
        ST_TEST: if (crosses) begin
          doing_y <= 1'b0;
        end else begin
          out_ch.valid <= 1'b1;
          out_ch.side <= cur_side;
          out_ch.seg_start_x <= ex0; out_ch.seg_start_y <= ey0;
          out_ch.seg_end_x <= ex1; out_ch.seg_end_y <= ey1;
          out_ch.run_last <= piece_last;
        end
        ST_MULQ: begin
          pm <= pmag[NW-2:0];
          neg <= mul_full[PW-1];
        end
        ST_DIVQ: if (div_done) begin
          if (!doing_y) begin
            ix <= coord_new;
            doing_y <= 1'b1;
          end else begin
            iy <= coord_new;
            out_ch.valid <= 1'b1;
            out_ch.side <= cur_side;
            out_ch.seg_start_x <= ex0; out_ch.seg_start_y <= ey0;
            out_ch.seg_end_x <= ix; out_ch.seg_end_y <= coord_new;
            out_ch.run_last <= 1'b0;
          end
        end
        ST_EMIT1: if (out_ch.ready) begin
          cur_side <= ~cur_side;
          out_ch.side <= ~cur_side;
          out_ch.seg_start_x <= ix; out_ch.seg_start_y <= iy;
          out_ch.seg_end_x <= ex1; out_ch.seg_end_y <= ey1;
          out_ch.run_last <= piece_last;
        end
        ST_EMIT2: if (out_ch.ready) out_ch.valid <= 1'b0;
        ST_NEXT: begin
          if (have_prev && last && !second) begin
            second <= 1'b1;
          end else begin
            if (!have_prev) begin
              fx <= vx;
              fy <= vy;
            end
            px <= vx;
            py <= vy;
            have_prev <= !last;
            if (last) cur_side <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

@@ tb/sv/tb_polygon_split_by_segment_unit.sv @@
`timescale 1ns / 1ps

module tb_polygon_split_by_segment_unit;
  import psplit_pkg::*;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic fin;
  } vertex_t;

  typedef struct {
    logic side;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic signed [15:0] ex;
    logic signed [15:0] ey;
    logic run_last;
  } seg_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CfgIndexWidth-1:0] cfg_index;
  logic [FieldWidth-1:0] cfg_data;

  psplit_in_if in_bus ();
  psplit_out_if out_bus ();

  polygon_split_by_segment_unit dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_bus),
    .out_ch(out_bus),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  vertex_t pending_vertices[$];
  seg_t expected_segs[$];
  vertex_t cur_vertex;

  longint cut_sx, cut_sy, cut_ex, cut_ey;
  longint first_x = 0;
  longint first_y = 0;
  longint prev_x = 0;
  longint prev_y = 0;
  bit have_prev = 1'b0;
  bit cur_side = 1'b0;

  bit hold_send;
  bit calm;
  int mismatches = 0;
  longint cycles = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic longint round_quot(longint n, longint d);
    longint mag;
    longint q;
    begin
      mag = (n < 0) ? -n : n;
      q = (2 * mag + d) / (2 * d);
      return (n < 0) ? -q : q;
    end
  endfunction

  task automatic push_seg(longint sx, longint sy, longint ex, longint ey);
    seg_t s;
    begin
      s.side = cur_side;
      s.sx = sx[15:0];
      s.sy = sy[15:0];
      s.ex = ex[15:0];
      s.ey = ey[15:0];
      s.run_last = 1'b0;
      expected_segs = {expected_segs, s};
    end
  endtask

  task automatic split_edge(longint px, longint py, longint qx, longint qy);
    longint ax, ay, bx, by, cx, cy, den, na, nb, ix, iy;
    begin
      if (!(px == qx && py == qy)) begin
        ax = qx - px;
        ay = qy - py;
        bx = cut_sx - cut_ex;
        by = cut_sy - cut_ey;
        cx = px - cut_sx;
        cy = py - cut_sy;
        den = ay * bx - ax * by;
        na = by * cx - bx * cy;
        nb = ax * cy - ay * cx;
        if (den < 0) begin
          den = -den;
          na = -na;
          nb = -nb;
        end
        if (den != 0 && na >= 0 && na <= den && nb >= 0 && nb <= den) begin
          ix = px + round_quot(ax * na, den);
          iy = py + round_quot(ay * na, den);
          push_seg(px, py, ix, iy);
          cur_side = ~cur_side;
          push_seg(ix, iy, qx, qy);
        end else begin
          push_seg(px, py, qx, qy);
        end
      end
    end
  endtask

  task automatic predict_vertex(vertex_t v);
    int n0;
    longint x, y;
    begin
      n0 = expected_segs.size();
      x = v.x;
      y = v.y;
      if (!have_prev) begin
        first_x = x;
        first_y = y;
      end else begin
        split_edge(prev_x, prev_y, x, y);
        if (v.fin) split_edge(x, y, first_x, first_y);
      end
      prev_x = x;
      prev_y = y;
      have_prev = 1'b1;
      if (v.fin) begin
        have_prev = 1'b0;
        cur_side = 1'b0;
      end
      if (expected_segs.size() > n0) expected_segs[expected_segs.size() - 1].run_last = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_bus.valid <= 1'b0;
      in_bus.vertex_x <= '0;
      in_bus.vertex_y <= '0;
      in_bus.final_vertex <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) predict_vertex(cur_vertex);
      if (!in_bus.valid || in_bus.ready) begin
        if (pending_vertices.size() > 0 && !hold_send &&
            (calm || $urandom_range(99) >= 26)) begin
          cur_vertex = pending_vertices.pop_front();
          in_bus.valid <= 1'b1;
          in_bus.vertex_x <= cur_vertex.x;
          in_bus.vertex_y <= cur_vertex.y;
          in_bus.final_vertex <= cur_vertex.fin;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    seg_t e;
    if (rst) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_segs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected output word: side=%0d start=(%0d,%0d)",
                                         out_bus.side, out_bus.seg_start_x, out_bus.seg_start_y);
        end else begin
          e = expected_segs.pop_front();
          if (out_bus.side !== e.side || out_bus.seg_start_x !== e.sx ||
              out_bus.seg_start_y !== e.sy || out_bus.seg_end_x !== e.ex ||
              out_bus.seg_end_y !== e.ey || out_bus.run_last !== e.run_last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("Mismatch: expected %0d (%0d,%0d)-(%0d,%0d) last=%0d",
                       e.side, e.sx, e.sy, e.ex, e.ey, e.run_last);
              $display("          got      %0d (%0d,%0d)-(%0d,%0d) last=%0d",
                       out_bus.side, out_bus.seg_start_x, out_bus.seg_start_y,
                       out_bus.seg_end_x, out_bus.seg_end_y, out_bus.run_last);
            end
          end
        end
      end
      out_bus.ready <= calm || ($urandom_range(99) >= 26);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 3000000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [CfgIndexWidth-1:0] idx, logic signed [15:0] val);
    begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_index <= idx;
      cfg_data <= val;
      @(posedge clk);
      cfg_we <= 1'b0;
      case (idx)
        RegCutStartX: cut_sx = val;
        RegCutStartY: cut_sy = val;
        RegCutEndX: cut_ex = val;
        default: cut_ey = val;
      endcase
    end
  endtask

  task automatic set_cut(int sx, int sy, int ex, int ey);
    begin
      write_reg(RegCutStartX, sx[15:0]);
      write_reg(RegCutStartY, sy[15:0]);
      write_reg(RegCutEndX, ex[15:0]);
      write_reg(RegCutEndY, ey[15:0]);
    end
  endtask

  task automatic add_vertex(int x, int y, bit fin);
    vertex_t v;
    begin
      v.x = x[15:0];
      v.y = y[15:0];
      v.fin = fin;
      pending_vertices = {pending_vertices, v};
    end
  endtask

  task automatic drain();
    begin
      while (pending_vertices.size() > 0 || in_bus.valid || expected_segs.size() > 0)
        @(posedge clk);
      repeat (400) @(posedge clk);
    end
  endtask

  function automatic int rand_coord(int span);
    if ($urandom_range(9) == 0) return $signed($urandom_range(65535) - 32768);
    return $signed($urandom_range(2 * span)) - span;
  endfunction

  task automatic add_random_polygons(int count, int span);
    int n, x, y;
    begin
      for (int i = 0; i < count; ) begin
        n = $urandom_range(6, 1);
        for (int k = 0; k < n; k++) begin
          if (k > 0 && $urandom_range(9) == 0) begin
            add_vertex(x, y, k == n - 1);
          end else begin
            x = rand_coord(span);
            y = rand_coord(span);
            add_vertex(x, y, (k == n - 1) || ($urandom_range(19) == 0));
          end
          i++;
        end
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cut_sx = 0; cut_sy = 0; cut_ex = 0; cut_ey = 0;
    hold_send = 0; calm = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // A zero-length cut from reset: every edge passes whole.
    add_vertex(-100, -100, 0);
    add_vertex(100, 100, 1);
    add_vertex(5, 5, 1);
    drain();

    set_cut(-32768, 0, 32767, 0);
    add_vertex(-100, -100, 0);
    add_vertex(100, -100, 0);
    add_vertex(100, 100, 0);
    add_vertex(100, 100, 0);
    add_vertex(-100, 100, 1);
    add_vertex(-50, 0, 0);
    add_vertex(50, 0, 0);
    add_vertex(50, 40, 1);
    add_vertex(-32768, -32768, 0);
    add_vertex(32767, 32767, 0);
    add_vertex(32767, -32768, 1);
    add_vertex(-32768, 32767, 0);
    add_vertex(-32768, -1, 1);
    add_vertex(7, 3, 0);
    add_vertex(-9, -4, 1);
    drain();

    set_cut(32767, -32768, -32768, 32767);
    add_vertex(-32768, -32768, 0);
    add_vertex(32767, 32767, 0);
    add_vertex(0, 32767, 1);
    drain();

    set_cut($urandom_range(4000) - 2000, $urandom_range(4000) - 2000,
            $urandom_range(4000) - 2000, $urandom_range(4000) - 2000);
    add_random_polygons(30, 3000);
    calm = 1;
    drain();
    calm = 0;

    set_cut(-32768, -32768, 32767, 32767);
    add_random_polygons(30, 20000);
    repeat (200) @(posedge clk);
    hold_send = 1;
    while (in_bus.valid || expected_segs.size() > 0) @(posedge clk);
    hold_send = 0;
    drain();

    set_cut($urandom_range(600) - 300, $urandom_range(600) - 300,
            $urandom_range(600) - 300, $urandom_range(600) - 300);
    add_random_polygons(30, 400);
    drain();

    set_cut($urandom_range(65535) - 32768, $urandom_range(65535) - 32768,
            $urandom_range(65535) - 32768, $urandom_range(65535) - 32768);
    add_random_polygons(30, 32767);
    drain();

    set_cut(-1000, 200, 1000, 200);
    add_random_polygons(30, 1500);
    drain();

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
